// ===== hw/rtl/tssf_pkg.sv =====
// ----------------------------------------------------------------------------
// tssf_pkg
// Shared constants and types for the tensor slice stream filter.
// ----------------------------------------------------------------------------
package tssf_pkg;

    localparam int MAX_RANK   = 4;
    localparam int DIM_BITS   = 12;
    localparam int VALUE_BITS = 32;
    localparam int OFS_BITS   = DIM_BITS + 1;

    localparam int RANK_BITS      = 3;
    localparam int DIM_SIZES_BITS = 48;
    localparam int MASK_BITS      = 4;
    localparam int OFFSETS_BITS   = 52;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = OFFSETS_BITS;

    localparam int TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

    localparam int FIFO_DEPTH     = 2;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_COUNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [RANK_BITS-1:0]      RANK_RESET      = 3'd4;
    localparam logic [DIM_SIZES_BITS-1:0] DIM_SIZES_RESET = 48'd68736258049;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RANK        = 3'd0,
        REG_DIM_SIZES   = 3'd1,
        REG_SLICED_MASK = 3'd2,
        REG_START       = 3'd3,
        REG_END         = 3'd4
    } cfg_reg_t;

    typedef logic [DIM_BITS-1:0] dim_t;

    typedef struct packed {
        logic [MAX_RANK-1:0] used;
        dim_t [MAX_RANK-1:0] size;
        dim_t [MAX_RANK-1:0] lo;
        dim_t [MAX_RANK-1:0] hi;
    } axis_cfg_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } result_t;

endpackage

// ===== hw/rtl/tensor_slice_stream_filter.sv =====
// A kept word is written into the output queue and leaves from its head.
// Throughput: one word per cycle while the output queue has room; the
// two-entry output queue sets how long the input keeps flowing while the
// output is stalled. Reset: asynchronous, active low; the configuration
// registers return to their defaults and the coordinate counter to all zero.
// ----------------------------------------------------------------------------
// tensor_slice_stream_filter
// Streams a row-major tensor and passes on the words inside the slice window.
// ----------------------------------------------------------------------------
module tensor_slice_stream_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tssf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tssf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tssf_pkg::TDATA_BITS-1:0]     s_tdata,   // element_value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tssf_pkg::TDATA_BITS-1:0]     m_tdata,   // out_value
    output logic                                m_tlast    // slice_last
);
    import tssf_pkg::*;

    axis_cfg_t axis_cfg;
    logic      queue_full;
    logic      push;
    result_t   push_data;

    tssf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .axis_cfg  (axis_cfg)
    );

    tssf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .axis_cfg   (axis_cfg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    tssf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // The input may only stall while output words are waiting.
    assert property (@(posedge clk) disable iff (!rst_n) !s_tready |-> m_tvalid)
        else $error("input stalled with an empty output queue");

    // A word leaving the queue always frees room for the next input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> s_tready)
        else $error("queue still full after an output word was taken");

    // A word is never written into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (s_tvalid && !queue_full))
        else $error("word pushed into a full queue");
`endif

endmodule

// ===== hw/rtl/tssf_cfg.sv =====
// ----------------------------------------------------------------------------
// tssf_cfg
// Configuration registers and the per-axis slice windows derived from them.
// ----------------------------------------------------------------------------
module tssf_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tssf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tssf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output tssf_pkg::axis_cfg_t                 axis_cfg
);
    import tssf_pkg::*;

    localparam int SIZE_EXT = MAX_RANK * DIM_BITS;
    localparam int OFS_EXT  = MAX_RANK * OFS_BITS;

    logic [RANK_BITS-1:0]      rank_reg;
    logic [DIM_SIZES_BITS-1:0] dim_sizes_reg;
    logic [MASK_BITS-1:0]      mask_reg;
    logic [OFFSETS_BITS-1:0]   start_reg;
    logic [OFFSETS_BITS-1:0]   end_reg;

    logic [SIZE_EXT-1:0] sizes_ext;
    logic [OFS_EXT-1:0]  starts_ext;
    logic [OFS_EXT-1:0]  ends_ext;
    logic [MAX_RANK-1:0] mask_ext;
    logic [RANK_BITS-1:0] rank_used;

    logic signed [OFS_BITS:0] n_s   [MAX_RANK];
    logic signed [OFS_BITS:0] s_raw [MAX_RANK];
    logic signed [OFS_BITS:0] e_raw [MAX_RANK];
    logic signed [OFS_BITS:0] s_adj [MAX_RANK];
    logic signed [OFS_BITS:0] e_adj [MAX_RANK];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg      <= RANK_RESET;
            dim_sizes_reg <= DIM_SIZES_RESET;
            mask_reg      <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RANK:        rank_reg      <= cfg_data[RANK_BITS-1:0];
                REG_DIM_SIZES:   dim_sizes_reg <= cfg_data[DIM_SIZES_BITS-1:0];
                REG_SLICED_MASK: mask_reg      <= cfg_data[MASK_BITS-1:0];
                REG_START:       start_reg     <= cfg_data[OFFSETS_BITS-1:0];
                REG_END:         end_reg       <= cfg_data[OFFSETS_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign sizes_ext  = SIZE_EXT'(dim_sizes_reg);
    assign starts_ext = OFS_EXT'(start_reg);
    assign ends_ext   = OFS_EXT'(end_reg);
    assign mask_ext   = MAX_RANK'(mask_reg);

    always_comb
    begin
        if (rank_reg == '0)
            rank_used = RANK_BITS'(1);
        else if (int'(rank_reg) > MAX_RANK)
            rank_used = RANK_BITS'(MAX_RANK);
        else
            rank_used = rank_reg;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_RANK; i++)
        begin
            axis_cfg.used[i] = int'(rank_used) > i;
            axis_cfg.size[i] = (sizes_ext[i*DIM_BITS +: DIM_BITS] == '0) ?
                               DIM_BITS'(1) : sizes_ext[i*DIM_BITS +: DIM_BITS];
            n_s[i]   = $signed({2'b00, axis_cfg.size[i]});
            s_raw[i] = $signed({starts_ext[i*OFS_BITS + OFS_BITS - 1],
                                starts_ext[i*OFS_BITS +: OFS_BITS]});
            e_raw[i] = $signed({ends_ext[i*OFS_BITS + OFS_BITS - 1],
                                ends_ext[i*OFS_BITS +: OFS_BITS]});
            s_adj[i] = (s_raw[i] < 0) ? s_raw[i] + n_s[i] : s_raw[i];
            e_adj[i] = (e_raw[i] < 0) ? e_raw[i] + n_s[i] : e_raw[i];

            if (!mask_ext[i])
            begin
                axis_cfg.lo[i] = '0;
                axis_cfg.hi[i] = axis_cfg.size[i];
            end
            else
            begin
                axis_cfg.lo[i] = (s_adj[i] < 0) ? '0 : s_adj[i][DIM_BITS-1:0];
                if (e_adj[i] < 0)
                    axis_cfg.hi[i] = '0;
                else if (e_adj[i] > n_s[i])
                    axis_cfg.hi[i] = axis_cfg.size[i];
                else
                    axis_cfg.hi[i] = e_adj[i][DIM_BITS-1:0];
            end
        end
    end

endmodule

// ===== hw/rtl/tssf_front.sv =====
// ----------------------------------------------------------------------------
// tssf_front
// Accepts input words, tracks the element coordinate and classifies each
// word as kept or dropped and as the last word of the slice.
// ----------------------------------------------------------------------------
module tssf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tssf_pkg::axis_cfg_t                 axis_cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tssf_pkg::TDATA_BITS-1:0]     s_tdata,
    input  logic                                queue_full,
    output logic                                push,
    output tssf_pkg::result_t                   push_data
);
    import tssf_pkg::*;

    dim_t coordinate_reg  [MAX_RANK];
    dim_t coordinate_next [MAX_RANK];

    logic accept;
    logic keep;
    logic last;
    logic carry;
    logic wrap;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && keep;

    assign push_data.value = s_tdata[VALUE_BITS-1:0];
    assign push_data.last  = last;

    always_comb
    begin
        keep  = 1'b1;
        last  = 1'b1;
        carry = 1'b1;
        wrap  = 1'b0;
        for (int i = MAX_RANK - 1; i >= 0; i--)
        begin
            coordinate_next[i] = coordinate_reg[i];
            if (axis_cfg.used[i])
            begin
                if ((coordinate_reg[i] < axis_cfg.lo[i]) ||
                    (coordinate_reg[i] >= axis_cfg.hi[i]))
                    keep = 1'b0;
                if ((DIM_BITS + 1)'(coordinate_reg[i]) !=
                    (DIM_BITS + 1)'(axis_cfg.hi[i]) - 1'b1)
                    last = 1'b0;
                wrap = ((DIM_BITS + 1)'(coordinate_reg[i]) + 1'b1) >=
                       (DIM_BITS + 1)'(axis_cfg.size[i]);
                if (carry)
                begin
                    coordinate_next[i] = wrap ? '0 : coordinate_reg[i] + 1'b1;
                end
                carry = carry && wrap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_RANK; i++)
                coordinate_reg[i] <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < MAX_RANK; i++)
                coordinate_reg[i] <= coordinate_next[i];
        end
    end

endmodule

// ===== hw/rtl/tssf_queue.sv =====
// ----------------------------------------------------------------------------
// tssf_queue
// Short queue of kept words that drives the output stream.
// ----------------------------------------------------------------------------
module tssf_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  tssf_pkg::result_t                   push_data,
    output logic                                full,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tssf_pkg::TDATA_BITS-1:0]     m_tdata,
    output logic                                m_tlast
);
    import tssf_pkg::*;

    result_t                    entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0]   rd_ptr_reg;
    logic [FIFO_COUNT_BITS-1:0] count_reg;
    logic [FIFO_COUNT_BITS-1:0] count_next;
    logic                       pop;

    assign full     = count_reg == FIFO_COUNT_BITS'(FIFO_DEPTH);
    assign m_tvalid = count_reg != '0;
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = TDATA_BITS'(entry_reg[rd_ptr_reg].value);
    assign m_tlast  = entry_reg[rd_ptr_reg].last;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule
